@@ src/bub_pkg.sv @@
// bub_pkg: shared types and constants of the 2x bilinear upscaler
// no dependencies; used by the front, queue, back and top level
`timescale 1ns / 1ps

package bub_pkg;

  // fixed field widths
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

  // cells one source pixel can complete, in emission order (bit positions)
  localparam int NUM_CELLS   = 4;
  localparam int CELL_INNER  = 0;  // cell above and to the left
  localparam int CELL_RIGHT  = 1;  // cell above, last column
  localparam int CELL_BOTTOM = 2;  // cell to the left, last row
  localparam int CELL_CORNER = 3;  // own cell, last row and column

  // four output pixels of a cell, in emission order
  localparam logic [1:0] SUB_COPY = 2'd0;
  localparam logic [1:0] SUB_HORZ = 2'd1;
  localparam logic [1:0] SUB_VERT = 2'd2;
  localparam logic [1:0] SUB_QUAD = 2'd3;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one classified source pixel with its neighborhood
  typedef struct packed {
    logic [PIX_W-1:0]     pix;       // current pixel
    logic [PIX_W-1:0]     up;        // pixel above
    logic [PIX_W-1:0]     left;      // pixel to the left
    logic [PIX_W-1:0]     up_left;   // pixel above and to the left
    logic [COORD_W-1:0]   row2;      // twice the source row, masked
    logic [COORD_W-1:0]   col2;      // twice the source column, masked
    logic [NUM_CELLS-1:0] cells;     // cells to emit
  } bub_job_t;

  // push side of the job queue
  typedef struct packed {
    logic     valid;
    bub_job_t job;
  } bub_push_t;

  // pop side of the job queue
  typedef struct packed {
    logic     empty;
    bub_job_t job;
  } bub_head_t;

endpackage

@@ src/bilinear_upscale_by_two.sv @@
// bilinear_upscale_by_two: top level of the streaming 2x bilinear upscaler
// depends on bub_pkg, bub_front, bub_queue, bub_back (and bub_ram below the front)
//
// Usage: source gray pixels enter in raster order on in_valid/in_stall, one per
// accepted item. Each item completes zero to four 2x2 cells of the doubled image
// and each cell leaves on out_valid/out_stall as four pixels with coordinates;
// out_run_last marks the final pixel caused by an item. Edges clamp to the
// nearest source pixel. cfg_index/cfg_data set source width (0) and height (1),
// clamped to 1..MAX; cfg_ready is always high; write only while idle.
// Flow: the first pixel of an item passes the stage-two register, the job
// queue and the output register. The back end sends one pixel per cycle
// unless out_stall holds the output register; an item yields four results in
// steady state, up to sixteen at bottom right, none in row 0 of a taller frame.
// The front takes an item per cycle while the two-entry job queue has room.
// Reset (rst_n low, synchronous) clears counters, queue and output valid and
// restores sizes 640 x 480; the line buffer needs no clearing. When the
// receiver stalls the output register holds, the queue fills, then in_stall rises.
`timescale 1ns / 1ps

module bilinear_upscale_by_two #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bub_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bub_pkg::COORD_W-1:0]   out_row,
  output logic [bub_pkg::COORD_W-1:0]   out_col,
  output logic [bub_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_run_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bub_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bub_pkg::CFG_W-1:0]     cfg_data
);

  import bub_pkg::*;

  bub_push_t push;
  bub_head_t head;
  logic      q_full;
  logic      pop;

  // accept and classify
  bub_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_in (in_pixel_in),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push)
  );

  // job queue
  bub_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  // cell expansion and output register
  bub_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_pixel_out (out_pixel_out),
    .out_run_last  (out_run_last)
  );

endmodule

@@ src/bub_ram.sv @@
// bub_ram: generic simple dual-port ram with registered read
// read returns the old contents when the same address is written
`timescale 1ns / 1ps

module bub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/bub_front.sv @@
// bub_front: config registers, raster counters, line buffer and classification
// depends on bub_pkg and bub_ram; pushes jobs into bub_queue
`timescale 1ns / 1ps

module bub_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bub_pkg::PIX_W-1:0]          in_pixel_in,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bub_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bub_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               q_full,
  output bub_pkg::bub_push_t                 push
);

  import bub_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
  localparam int CMP_W = CFG_W + 2;

  // clamped sizes
  logic [CW:0]          w_r, w_nxt;
  logic [RW:0]          h_r, h_nxt;
  logic [CW:0]          w_clamp;
  logic [RW:0]          h_clamp;

  // raster position of the next item
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;

  // second stage: waits for the line buffer read
  logic                 s1_v_r, s1_v_nxt;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [COORD_W-1:0]   s1_row2_r;
  logic [COORD_W-1:0]   s1_col2_r;
  logic [NUM_CELLS-1:0] s1_cells_r;

  // neighbors carried from the previous item
  logic [PIX_W-1:0]     left_r;
  logic [PIX_W-1:0]     up_left_r;

  logic                 accept;
  logic                 s1_move;
  logic                 col_wrap;
  logic [CW-1:0]        c;
  logic [RW:0]          row_t;
  logic [RW-1:0]        r;
  logic                 last_c;
  logic                 last_r;
  logic [NUM_CELLS-1:0] cells;
  logic [PIX_W-1:0]     up;

  assign cfg_ready = 1'b1;

  // clamp written sizes to 1..max
  always_comb begin
    if (cfg_data == '0) begin
      w_clamp = (CW+1)'(1);
    end else if ({2'b00, cfg_data} > CMP_W'(MAX_WIDTH)) begin
      w_clamp = (CW+1)'(MAX_WIDTH);
    end else begin
      w_clamp = (CW+1)'(cfg_data);
    end
    if (cfg_data == '0) begin
      h_clamp = (RW+1)'(1);
    end else if ({2'b00, cfg_data} > CMP_W'(MAX_HEIGHT)) begin
      h_clamp = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_clamp = (RW+1)'(cfg_data);
    end
  end

  // register writes
  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOURCE_WIDTH:  w_nxt = w_clamp;
        CFG_SOURCE_HEIGHT: h_nxt = h_clamp;
        default: ;
      endcase
    end
  end

  // position of this item, wrapping counters left beyond a shrunk size
  always_comb begin
    col_wrap = ({1'b0, col_r} >= w_r);
    c        = col_wrap ? '0 : col_r;
    row_t    = {1'b0, row_r} + (RW+1)'(col_wrap);
    r        = (row_t >= h_r) ? '0 : RW'(row_t);
    last_c   = (c == CW'(w_r - (CW+1)'(1)));
    last_r   = (r == RW'(h_r - (RW+1)'(1)));
  end

  // cells completed by this pixel
  always_comb begin
    cells              = '0;
    cells[CELL_INNER]  = (r != '0) && (c != '0);
    cells[CELL_RIGHT]  = (r != '0) && last_c;
    cells[CELL_BOTTOM] = last_r && (c != '0);
    cells[CELL_CORNER] = last_r && last_c;
  end

  // handshake: stage two leaves when it has nothing to push or the queue has room
  assign s1_move  = s1_v_r && ((s1_cells_r == '0) || !q_full);
  assign in_stall = s1_v_r && !s1_move;
  assign accept   = in_valid && !in_stall;

  // counter advance
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_c) begin
        col_nxt = '0;
        row_nxt = last_r ? '0 : r + 1'b1;
      end else begin
        col_nxt = c + 1'b1;
        row_nxt = r;
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= (CW+1)'(W_RST);
      h_r       <= (RW+1)'(H_RST);
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      left_r    <= '0;
      up_left_r <= '0;
    end else begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
      if (s1_move) begin
        left_r    <= s1_pix_r;
        up_left_r <= up;
      end
    end
  end

  // stage two payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pixel_in;
      s1_row2_r  <= COORD_W'({r, 1'b0});
      s1_col2_r  <= COORD_W'({c, 1'b0});
      s1_cells_r <= cells;
    end
  end

  // previous row line buffer, read and overwritten at the same column
  bub_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (in_pixel_in),
    .re    (accept),
    .raddr (c),
    .rdata (up)
  );

  // job toward the back end
  always_comb begin
    push.valid       = s1_v_r && (s1_cells_r != '0) && !q_full;
    push.job.pix     = s1_pix_r;
    push.job.up      = up;
    push.job.left    = left_r;
    push.job.up_left = up_left_r;
    push.job.row2    = s1_row2_r;
    push.job.col2    = s1_col2_r;
    push.job.cells   = s1_cells_r;
  end

endmodule

@@ src/bub_queue.sv @@
// bub_queue: short job queue between front and back end
// depends on bub_pkg
`timescale 1ns / 1ps

module bub_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  bub_pkg::bub_push_t push,
  output logic               full,
  input  logic               pop,
  output bub_pkg::bub_head_t head
);

  import bub_pkg::*;

  bub_job_t          ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.empty = (cnt_r == '0);
  assign head.job   = ent_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && !head.empty;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

@@ src/bub_back.sv @@
// bub_back: expands jobs into cell pixels, one per cycle unless stalled
// depends on bub_pkg; pops bub_queue and drives the output register
`timescale 1ns / 1ps

module bub_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bub_pkg::bub_head_t           head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bub_pkg::COORD_W-1:0]  out_row,
  output logic [bub_pkg::COORD_W-1:0]  out_col,
  output logic [bub_pkg::PIX_W-1:0]    out_pixel_out,
  output logic                         out_run_last
);

  import bub_pkg::*;

  // progress through the head job
  logic                 started_r, started_nxt;
  logic [NUM_CELLS-1:0] mask_r, mask_nxt;
  logic [1:0]           sub_r, sub_nxt;

  // output register
  logic                 out_v_r, out_v_nxt;
  logic [COORD_W-1:0]   row_r;
  logic [COORD_W-1:0]   col_r;
  logic [PIX_W-1:0]     pix_r;
  logic                 last_r;

  logic [NUM_CELLS-1:0] rem;
  logic [NUM_CELLS-1:0] cur;
  logic [NUM_CELLS-1:0] rest;
  logic                 adv;
  logic                 job_last;
  logic [PIX_W-1:0]     pa, pb, pc, pd;
  logic [COORD_W-1:0]   row_b, col_b;
  logic [COORD_W-1:0]   row_m2, col_m2;
  logic [PIX_W:0]       sum_ab, sum_ac;
  logic [PIX_W+1:0]     sum_quad;
  logic [PIX_W-1:0]     val;

  // pick the first cell still pending
  always_comb begin
    rem = started_r ? mask_r : head.job.cells;
    cur = '0;
    priority if (rem[CELL_INNER]) begin
      cur[CELL_INNER] = 1'b1;
    end else if (rem[CELL_RIGHT]) begin
      cur[CELL_RIGHT] = 1'b1;
    end else if (rem[CELL_BOTTOM]) begin
      cur[CELL_BOTTOM] = 1'b1;
    end else begin
      cur[CELL_CORNER] = 1'b1;
    end
    rest = rem & ~cur;
  end

  // corner pixels and origin of the chosen cell, clamped at the edges
  always_comb begin
    row_m2 = head.job.row2 - COORD_W'(2);
    col_m2 = head.job.col2 - COORD_W'(2);
    pa     = head.job.pix;
    pb     = head.job.pix;
    pc     = head.job.pix;
    pd     = head.job.pix;
    row_b  = head.job.row2;
    col_b  = head.job.col2;
    if (cur[CELL_INNER]) begin
      pa    = head.job.up_left;
      pb    = head.job.up;
      pc    = head.job.left;
      row_b = row_m2;
      col_b = col_m2;
    end else if (cur[CELL_RIGHT]) begin
      pa    = head.job.up;
      pb    = head.job.up;
      row_b = row_m2;
    end else if (cur[CELL_BOTTOM]) begin
      pa    = head.job.left;
      pc    = head.job.left;
      col_b = col_m2;
    end
  end

  // floor averages
  always_comb begin
    sum_ab   = {1'b0, pa} + {1'b0, pb};
    sum_ac   = {1'b0, pa} + {1'b0, pc};
    sum_quad = {2'b00, pa} + {2'b00, pb} + {2'b00, pc} + {2'b00, pd};
    unique case (sub_r)
      SUB_COPY: val = pa;
      SUB_HORZ: val = sum_ab[PIX_W:1];
      SUB_VERT: val = sum_ac[PIX_W:1];
      SUB_QUAD: val = sum_quad[PIX_W+1:2];
      default:  val = pa;
    endcase
  end

  // advance when a job is waiting and the output register is free
  assign adv      = !head.empty && (!out_v_r || !out_stall);
  assign job_last = (sub_r == SUB_QUAD) && (rest == '0);
  assign pop      = adv && job_last;

  always_comb begin
    started_nxt = started_r;
    mask_nxt    = mask_r;
    sub_nxt     = sub_r;
    if (adv) begin
      if (job_last) begin
        started_nxt = 1'b0;
        sub_nxt     = SUB_COPY;
      end else if (sub_r == SUB_QUAD) begin
        started_nxt = 1'b1;
        mask_nxt    = rest;
        sub_nxt     = SUB_COPY;
      end else begin
        started_nxt = 1'b1;
        mask_nxt    = rem;
        sub_nxt     = sub_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_stall) begin
      out_v_nxt = out_v_r;
    end else begin
      out_v_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      mask_r    <= '0;
      sub_r     <= SUB_COPY;
      out_v_r   <= 1'b0;
    end else begin
      started_r <= started_nxt;
      mask_r    <= mask_nxt;
      sub_r     <= sub_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      row_r  <= {row_b[COORD_W-1:1], sub_r[1]};
      col_r  <= {col_b[COORD_W-1:1], sub_r[0]};
      pix_r  <= val;
      last_r <= job_last;
    end
  end

  assign out_valid     = out_v_r;
  assign out_row       = row_r;
  assign out_col       = col_r;
  assign out_pixel_out = pix_r;
  assign out_run_last  = last_r;

endmodule

@@ src/bub_checker.sv @@
// bub_checker: port-level checks of the 2x bilinear upscaler
// depends on bub_pkg; bound to bilinear_upscale_by_two below
`timescale 1ns / 1ps

module bub_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bub_pkg::COORD_W-1:0] out_row,
  input logic [bub_pkg::COORD_W-1:0] out_col,
  input logic [bub_pkg::PIX_W-1:0]   out_pixel_out,
  input logic                        out_run_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped under stall");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_row, out_col, out_pixel_out, out_run_last}))
    else $error("output payload changed under stall");

  // the last result of an item is always the four-pixel average of a cell
  a_last_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_row[0] && out_col[0])
    else $error("run_last on a pixel other than the cell's last");

  // a copied source pixel never ends an item's run
  a_copy_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row[0] && !out_col[0] |-> !out_run_last)
    else $error("run_last on a cell's first pixel");

  // nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind bilinear_upscale_by_two bub_checker u_bub_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_row       (out_row),
  .out_col       (out_col),
  .out_pixel_out (out_pixel_out),
  .out_run_last  (out_run_last)
);

@@ test/tb_bilinear_upscale_by_two.sv @@
// tb_bilinear_upscale_by_two: self-checking testbench of the 2x bilinear upscaler
// depends on bub_pkg and bilinear_upscale_by_two; predicts every output item in the
// testbench and checks it field by field under random idling on both channels
`timescale 1ns / 1ps

module tb_bilinear_upscale_by_two;
  import bub_pkg::*;

  localparam int MAX_SIDE_W = 2048;
  localparam int MAX_SIDE_H = 2048;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 300;
  localparam int EDGE_ITEMS = 24;

  // one expected output pixel
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pix;
    logic               last;
  } out_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_run_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [CFG_W-1:0] width_reg = CFG_W'(640);
  logic [CFG_W-1:0] height_reg = CFG_W'(480);
  bit [PIX_W-1:0]   prev_row [MAX_SIDE_W];
  bit [PIX_W-1:0]   left_pix = '0;
  bit [PIX_W-1:0]   upleft_pix = '0;
  int               row_pos = 0;
  int               col_pos = 0;
  int               store_reach = 0;

  out_pixel_t upscaled_due [$];
  int         fail_count = 0;
  bit         calm = 1'b0;

  bilinear_upscale_by_two #(
    .MAX_WIDTH (MAX_SIDE_W),
    .MAX_HEIGHT(MAX_SIDE_H)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_pixel_out(out_pixel_out),
    .out_run_last (out_run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // receiver stalls at random outside calm stretches
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 16);
  end

  // size register value as the block uses it
  function automatic int eff_size(input logic [CFG_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // four pixels of one cell: copy, horizontal, vertical and quad average
  function automatic void queue_cell(input int ci, input int cj, input int a, input int b,
                                     input int c, input int d, input bit closes);
    int vals [4];
    int rr;
    int cc;
    out_pixel_t px;
    vals[SUB_COPY] = a;
    vals[SUB_HORZ] = (a + b) >> 1;
    vals[SUB_VERT] = (a + c) >> 1;
    vals[SUB_QUAD] = (a + b + c + d) >> 2;
    for (int k = 0; k < 4; k++) begin
      rr = 2 * ci + (k >> 1);
      cc = 2 * cj + (k & 1);
      px.row = rr[COORD_W-1:0];
      px.col = cc[COORD_W-1:0];
      px.pix = vals[k][PIX_W-1:0];
      px.last = closes && (k == int'(SUB_QUAD));
      upscaled_due.push_back(px);
    end
  endfunction

  // advance the predictor by one source pixel and queue the cells it completes
  function automatic void predict_upscale(input logic [PIX_W-1:0] p);
    int w;
    int h;
    int r;
    int c;
    int up;
    int lf;
    int ul;
    int pv;
    int left_cells;
    bit do_inner;
    bit do_right;
    bit do_bottom;
    bit do_corner;
    w = eff_size(width_reg, MAX_SIDE_W);
    h = eff_size(height_reg, MAX_SIDE_H);
    // counters beyond a shrunk size wrap first
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    up = int'(prev_row[c]);
    lf = int'(left_pix);
    ul = int'(upleft_pix);
    pv = int'(p);
    do_inner = (r > 0) && (c > 0);
    do_right = (r > 0) && (c == w - 1);
    do_bottom = (r == h - 1) && (c > 0);
    do_corner = (r == h - 1) && (c == w - 1);
    left_cells = int'(do_inner) + int'(do_right) + int'(do_bottom) + int'(do_corner);
    if (do_inner) begin
      left_cells--;
      queue_cell(r - 1, c - 1, ul, up, lf, pv, left_cells == 0);
    end
    if (do_right) begin
      left_cells--;
      queue_cell(r - 1, c, up, up, pv, pv, left_cells == 0);
    end
    if (do_bottom) begin
      left_cells--;
      queue_cell(r, c - 1, lf, pv, lf, pv, left_cells == 0);
    end
    if (do_corner) begin
      queue_cell(r, c, pv, pv, pv, pv, 1'b1);
    end
    upleft_pix = up[PIX_W-1:0];
    left_pix = p;
    prev_row[c] = p;
    if (c + 1 > store_reach) store_reach = c + 1;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // mostly uniform, with the extremes now and then
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // small size, zero now and then
  function automatic logic [CFG_W-1:0] pick_side(input int maxv);
    if ($urandom_range(9) == 0) return '0;
    return CFG_W'($urandom_range(1, maxv));
  endfunction

  // send one source pixel, with an occasional gap before it
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    if (!calm && ($urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_upscale(p);
  endtask

  // stop sending and wait until every expected item has come out
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (upscaled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both size registers back to back; block must be idle
  task automatic set_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    logic [CFG_IDX_W-1:0] idx [2];
    logic [CFG_W-1:0]     val [2];
    idx[0] = CFG_SOURCE_WIDTH;
    idx[1] = CFG_SOURCE_HEIGHT;
    val[0] = w;
    val[1] = h;
    cfg_valid <= 1'b1;
    for (int k = 0; k < 2; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (idx[k] == CFG_SOURCE_WIDTH) width_reg = val[k];
      else if (idx[k] == CFG_SOURCE_HEIGHT) height_reg = val[k];
    end
    cfg_valid <= 1'b0;
  endtask

  // reset sizes, then a mid-frame shrink that wraps the column count
  task automatic test_reset_and_wrap();
    send_pixel(8'd10);
    send_pixel(8'd201);
    send_pixel(8'd77);
    settle_block();
    set_sizes(CFG_W'(2), CFG_W'(2));
    // bottom right pixel of a 2x2 frame completes all four cells
    send_pixel(8'd255);
    send_pixel(8'd0);
  endtask

  // field extremes and odd sums for the floor averages
  task automatic test_pixel_extremes();
    settle_block();
    set_sizes(CFG_W'(3), CFG_W'(2));
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd254);
    send_pixel(8'd1);
    send_pixel(8'd255);
    send_pixel(8'd0);
  endtask

  // zero sizes act as a 1x1 frame
  task automatic test_zero_sizes();
    settle_block();
    set_sizes('0, '0);
    send_pixel(8'd128);
    send_pixel(8'd127);
  endtask

  // height shrunk mid-frame wraps the row count to the next frame
  task automatic test_height_wrap();
    settle_block();
    set_sizes(CFG_W'(3), CFG_W'(4));
    repeat (5) send_pixel(rand_pixel());
    settle_block();
    set_sizes(CFG_W'(3), CFG_W'(1));
    repeat (4) send_pixel(rand_pixel());
  endtask

  // oversized width clamps to the widest row, start of the row only
  task automatic test_widest_row();
    settle_block();
    set_sizes('1, CFG_W'(1));
    repeat (EDGE_ITEMS) send_pixel(rand_pixel());
  endtask

  // oversized height clamps to the tallest column, top of the column only
  task automatic test_tallest_column();
    settle_block();
    set_sizes(CFG_W'(1), '1);
    repeat (EDGE_ITEMS) send_pixel(rand_pixel());
  endtask

  // random small frames, some resized mid-frame
  task automatic test_random_frames();
    logic [CFG_W-1:0] new_w;
    settle_block();
    set_sizes(CFG_W'(4), CFG_W'(3));
    for (int sent = 0; sent < RANDOM_ITEMS; sent++) begin
      calm = (sent >= 120) && (sent < 200);
      // let the block run dry once
      if (sent == 250) settle_block();
      if (row_pos == 0 && col_pos == 0 && $urandom_range(1) == 0) begin
        settle_block();
        set_sizes(pick_side(9), pick_side(6));
      end else if ($urandom_range(39) == 0) begin
        settle_block();
        new_w = pick_side(9);
        // never grow past line entries that were written
        if (eff_size(new_w, MAX_SIDE_W) > store_reach) new_w = width_reg;
        set_sizes(new_w, pick_side(6));
      end
      send_pixel(rand_pixel());
    end
    calm = 1'b0;
  endtask

  // compare each output item with the oldest expectation
  always @(posedge clk) begin : check_results
    out_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (upscaled_due.size() == 0) begin
        $error("unexpected item: row %0d col %0d pixel %0d", out_row, out_col, out_pixel_out);
        fail_count++;
      end else begin
        want = upscaled_due.pop_front();
        if (out_row !== want.row) begin
          $error("out_row expected %0d actual %0d", want.row, out_row);
          fail_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col expected %0d actual %0d", want.col, out_col);
          fail_count++;
        end
        if (out_pixel_out !== want.pix) begin
          $error("pixel_out expected %0d actual %0d", want.pix, out_pixel_out);
          fail_count++;
        end
        if (out_run_last !== want.last) begin
          $error("run_last expected %0d actual %0d", want.last, out_run_last);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("bilinear_upscale_by_two: mismatch");
    $finish;
  end

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_wrap();
    test_pixel_extremes();
    test_zero_sizes();
    test_height_wrap();
    test_widest_row();
    test_tallest_column();
    test_random_frames();
    settle_block();
    if (fail_count == 0) begin
      $display("bilinear_upscale_by_two: match");
    end else begin
      $display("bilinear_upscale_by_two: mismatch");
    end
    $finish;
  end

endmodule

@@ bilinear_upscale_by_two.f @@
src/bub_pkg.sv
src/bub_ram.sv
src/bub_front.sv
src/bub_queue.sv
src/bub_back.sv
src/bilinear_upscale_by_two.sv
src/bub_checker.sv
test/tb_bilinear_upscale_by_two.sv
